@@ src/wema_pkg.sv @@
// ----------------------------------------------------------------------------
// wema_pkg
// Shared types, constants and register codes of the weighted EMA virtual
// temperature sensor.
// ----------------------------------------------------------------------------
package wema_pkg;

  localparam int NUM_SENSORS_DEF = 2;

  // Field widths of one request and one result.
  localparam int IDX_W    = 1;
  localparam int SAMPLE_W = 18;
  localparam int FILT_W   = 19;
  localparam int SUM_W    = 20;

  // Configuration registers.
  localparam int PM_W       = 10;
  localparam int OFFSET_W   = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int REGS_PER_SENSOR = 3;
  localparam int REG_ALPHA_OFS   = 0;
  localparam int REG_OFFSET_OFS  = 1;
  localparam int REG_WEIGHT_OFS  = 2;

  localparam logic [PM_W-1:0] PER_MILLE     = 10'd1000;
  localparam logic [PM_W-1:0] ALPHA_RESET   = 10'd1000;
  localparam logic [PM_W-1:0] WEIGHT0_RESET = 10'd1000;
  localparam logic [PM_W-1:0] WEIGHTN_RESET = 10'd0;

  // Division by 1000 of a magnitude below 2**28: (n * RECIP_1000) >> DIV_SHIFT
  // is exact over that whole range.
  localparam int MAG_W     = 28;
  localparam int RECIP_W   = 29;
  localparam int DIV_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 20'sd524287;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -20'sd524288;

  typedef struct packed {
    logic [PM_W-1:0]            alpha;
    logic signed [OFFSET_W-1:0] offset;
    logic [PM_W-1:0]            weight;
  } sensor_cfg_t;

  // Filtered value handed from the filter to the accumulator.
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic                     present;
    logic signed [FILT_W-1:0] filt;
    logic [PM_W-1:0]          weight;
  } filt_req_t;

endpackage

@@ src/wema_cfg.sv @@
// ----------------------------------------------------------------------------
// wema_cfg
// Per-sensor configuration registers; alpha and weight clamp to 1000.
// ----------------------------------------------------------------------------
module wema_cfg #(
  parameter int NUM_SENSORS = wema_pkg::NUM_SENSORS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [wema_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wema_pkg::CFG_DATA_W-1:0]  cfg_data,
  output wema_pkg::sensor_cfg_t            cfg [NUM_SENSORS]
);
  import wema_pkg::*;

  logic [PM_W-1:0] pm_value;

  assign pm_value = (cfg_data[PM_W-1:0] > PER_MILLE) ? PER_MILLE : cfg_data[PM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        cfg[s].alpha  <= ALPHA_RESET;
        cfg[s].offset <= '0;
        cfg[s].weight <= (s == 0) ? WEIGHT0_RESET : WEIGHTN_RESET;
      end
    end else if (cfg_write) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        if (cfg_index == CFG_IDX_W'(s * REGS_PER_SENSOR + REG_ALPHA_OFS)) begin
          cfg[s].alpha <= pm_value;
        end
        if (cfg_index == CFG_IDX_W'(s * REGS_PER_SENSOR + REG_OFFSET_OFS)) begin
          cfg[s].offset <= $signed(cfg_data[OFFSET_W-1:0]);
        end
        if (cfg_index == CFG_IDX_W'(s * REGS_PER_SENSOR + REG_WEIGHT_OFS)) begin
          cfg[s].weight <= pm_value;
        end
      end
    end
  end

endmodule

@@ src/wema_filter.sv @@
// ----------------------------------------------------------------------------
// wema_filter
// Input register, offset removal and per-sensor exponential average. The
// weighted mix is formed in one stage and divided by 1000 in the next, where
// the smoothed value is written back.
// ----------------------------------------------------------------------------
module wema_filter #(
  parameter int NUM_SENSORS = wema_pkg::NUM_SENSORS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wema_pkg::sensor_cfg_t                 cfg [NUM_SENSORS],
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wema_pkg::IDX_W-1:0]            sensor_index,
  input  logic signed [wema_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  last_sensor,
  output wema_pkg::filt_req_t                   fout,
  input  logic                                  fout_ready
);
  import wema_pkg::*;

  // Input register.
  logic                       r0_valid;
  logic [IDX_W-1:0]           r0_idx;
  logic signed [SAMPLE_W-1:0] r0_sample;
  logic                       r0_last;

  // Mix stage register.
  logic                     ra_valid;
  logic [IDX_W-1:0]         ra_idx;
  logic                     ra_last;
  logic                     ra_present;
  logic                     ra_seed;
  logic signed [FILT_W-1:0] ra_x;
  logic                     ra_neg;
  logic [MAG_W-1:0]         ra_mag;

  logic signed [FILT_W-1:0] smoothed [NUM_SENSORS];

  logic                      r0_present;
  logic [IDX_W-1:0]          sel_a;
  logic signed [FILT_W-1:0]  x_a;
  logic signed [FILT_W-1:0]  old_a;
  logic signed [PM_W:0]      a_s;
  logic signed [PM_W:0]      ia_s;
  logic signed [MAG_W+1:0]   mix;
  logic [MAG_W+1:0]          mix_abs;
  logic                      hazard;
  logic                      r0_adv;
  logic                      ra_ready;
  logic                      rb_ready;
  logic [MAG_W+RECIP_W-1:0]  quot_prod;
  logic [FILT_W-1:0]         quot;
  logic signed [FILT_W-1:0]  filt_b;

  assign r0_present = (int'(r0_idx) < NUM_SENSORS);
  assign sel_a      = r0_present ? r0_idx : '0;

  always_comb begin
    x_a   = {r0_sample[SAMPLE_W-1], r0_sample}
          - {{(FILT_W-OFFSET_W){cfg[sel_a].offset[OFFSET_W-1]}}, cfg[sel_a].offset};
    old_a = smoothed[sel_a];
    a_s   = $signed({1'b0, cfg[sel_a].alpha});
    ia_s  = $signed({1'b0, PER_MILLE - cfg[sel_a].alpha});
    // alpha*x + (1000-alpha)*old stays below 2**28 in magnitude.
    mix     = a_s * x_a + ia_s * old_a;
    mix_abs = mix[MAG_W+1] ? (~mix + 1'b1) : mix;
  end

  // A request may not read a smoothed value that the mix stage is about to
  // rewrite, so it is held while a request for the same sensor sits in that stage.
  assign hazard   = ra_valid && ra_present && r0_present && (ra_idx == r0_idx);
  assign rb_ready = !fout.valid || fout_ready;
  assign ra_ready = !ra_valid || rb_ready;
  assign r0_adv   = r0_valid && ra_ready && !hazard;
  assign in_stall = r0_valid && !r0_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid <= 1'b0;
    end else if (!in_stall) begin
      r0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      r0_idx    <= sensor_index;
      r0_sample <= sample;
      r0_last   <= last_sensor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ra_valid <= 1'b0;
    end else if (ra_ready) begin
      ra_valid <= r0_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (r0_adv) begin
      ra_idx     <= sel_a;
      ra_last    <= r0_last;
      ra_present <= r0_present;
      ra_seed    <= (old_a == '0);
      ra_x       <= x_a;
      ra_neg     <= mix[MAG_W+1];
      ra_mag     <= mix_abs[MAG_W-1:0];
    end
  end

  // Divide the mix by 1000, truncating toward zero; an unseeded sensor takes the corrected sample.
  always_comb begin
    quot_prod = ra_mag * RECIP_1000;
    quot      = quot_prod[DIV_SHIFT +: FILT_W];
    if (!ra_present) begin
      filt_b = '0;
    end else if (ra_seed) begin
      filt_b = ra_x;
    end else if (ra_neg) begin
      filt_b = $signed(~quot + 1'b1);
    end else begin
      filt_b = $signed(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        smoothed[s] <= '0;
      end
    end else if (ra_valid && rb_ready && ra_present) begin
      smoothed[ra_idx] <= filt_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fout.valid <= 1'b0;
    end else if (rb_ready) begin
      fout.valid <= ra_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rb_ready && ra_valid) begin
      fout.last    <= ra_last;
      fout.present <= ra_present;
      fout.filt    <= filt_b;
      fout.weight  <= cfg[ra_idx].weight;
    end
  end

endmodule

@@ src/wema_accum.sv @@
// ----------------------------------------------------------------------------
// wema_accum
// Weights the filtered value, divides by 1000 and adds it to the saturating
// sweep accumulator; holds the result register.
// ----------------------------------------------------------------------------
module wema_accum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wema_pkg::filt_req_t                  fin,
  output logic                                 fin_ready,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wema_pkg::FILT_W-1:0]   filtered_value,
  output logic signed [wema_pkg::SUM_W-1:0]    running_sum,
  output logic                                 sweep_done
);
  import wema_pkg::*;

  logic                     rc_valid;
  logic                     rc_last;
  logic                     rc_present;
  logic signed [FILT_W-1:0] rc_filt;
  logic                     rc_neg;
  logic [MAG_W-1:0]         rc_mag;

  logic signed [SUM_W-1:0]  acc;

  logic [FILT_W-1:0]         filt_abs;
  logic [PM_W+FILT_W-1:0]    wprod;
  logic [MAG_W+RECIP_W-1:0]  quot_prod;
  logic [FILT_W-1:0]         quot;
  logic signed [SUM_W-1:0]   term;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum;
  logic                      out_ready;
  logic                      rc_ready;

  assign out_ready = !out_valid || !out_stall;
  assign rc_ready  = !rc_valid || out_ready;
  assign fin_ready = rc_ready;

  always_comb begin
    filt_abs = fin.filt[FILT_W-1] ? (~fin.filt + 1'b1) : fin.filt;
    wprod    = fin.weight * filt_abs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc_valid <= 1'b0;
    end else if (rc_ready) begin
      rc_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rc_ready && fin.valid) begin
      rc_last    <= fin.last;
      rc_present <= fin.present;
      rc_filt    <= fin.filt;
      rc_neg     <= fin.filt[FILT_W-1];
      rc_mag     <= wprod[MAG_W-1:0];
    end
  end

  always_comb begin
    quot_prod = rc_mag * RECIP_1000;
    quot      = quot_prod[DIV_SHIFT +: FILT_W];
    term      = rc_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    sum_wide  = {acc[SUM_W-1], acc} + {term[SUM_W-1], term};
    if (!rc_present) begin
      sum = acc;
    end else if (sum_wide > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) begin
      sum = SUM_MAX;
    end else if (sum_wide < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) begin
      sum = SUM_MIN;
    end else begin
      sum = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
    end else if (out_ready) begin
      out_valid <= rc_valid;
      if (rc_valid) begin
        acc <= rc_last ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && rc_valid) begin
      filtered_value <= rc_filt;
      running_sum    <= sum;
      sweep_done     <= rc_last;
    end
  end

endmodule

@@ src/weighted_ema_virtual_temp_sensor_top.sv @@
// ----------------------------------------------------------------------------
// weighted_ema_virtual_temp_sensor_top
// Virtual temperature sensor: per-sensor offset removal, exponential
// smoothing and a weighted per-sweep sum.
// ----------------------------------------------------------------------------
// Each request gives exactly one result, carried through the input, mix,
// divide, accumulator and result registers. A request is accepted every
// cycle as long as consecutive requests name different sensors and the
// output is not stalled; a request for the same sensor as the one just
// before it waits until that one has left the mix stage register, because
// the smoothed value of a sensor is read in the mix stage and written back
// only at the end of the following divide stage. Configuration writes take
// effect at once and should be made while no request is in flight.
module weighted_ema_virtual_temp_sensor_top #(
  parameter int NUM_SENSORS = wema_pkg::NUM_SENSORS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [wema_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wema_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [wema_pkg::IDX_W-1:0]           sensor_index,
  input  logic signed [wema_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last_sensor,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wema_pkg::FILT_W-1:0]   filtered_value,
  output logic signed [wema_pkg::SUM_W-1:0]    running_sum,
  output logic                                 sweep_done
);
  import wema_pkg::*;

  sensor_cfg_t cfg [NUM_SENSORS];
  filt_req_t   filt_req;
  logic        filt_ready;

  wema_cfg #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wema_filter #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_filter (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sensor_index (sensor_index),
    .sample       (sample),
    .last_sensor  (last_sensor),
    .fout         (filt_req),
    .fout_ready   (filt_ready)
  );

  wema_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .fin            (filt_req),
    .fin_ready      (filt_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value),
    .running_sum    (running_sum),
    .sweep_done     (sweep_done)
  );

endmodule

@@ tb/sv/weighted_ema_virtual_temp_sensor_top_tb.sv @@
// ----------------------------------------------------------------------------
// weighted_ema_virtual_temp_sensor_top_tb
// Self-checking bench for the weighted EMA virtual temperature sensor. A
// directed opening covers seeding, range edges and saturation. Random sweeps
// follow under changing register settings and changing idle and stall
// pressure. A scoreboard class predicts each result from the accepted
// request and checks every result in order.
// ----------------------------------------------------------------------------
module weighted_ema_virtual_temp_sensor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wema_pkg::*;

  localparam int N_SENS       = NUM_SENSORS_DEF;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int BLOCK_ITEMS  = 60;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'((1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(-(1 <<< (SAMPLE_W - 1)));
  localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = OFFSET_W'((1 <<< (OFFSET_W - 1)) - 1);
  localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = OFFSET_W'(-(1 <<< (OFFSET_W - 1)));
  localparam logic [PM_W-1:0]            PM_TOP     = '1;

  typedef struct {
    logic signed [FILT_W-1:0] filt;
    logic signed [SUM_W-1:0]  sum;
    logic                     done;
  } fusion_result_t;

  class temp_fusion_scoreboard;
    sensor_cfg_t              cfg [N_SENS];
    logic signed [FILT_W-1:0] smoothed [N_SENS];
    logic signed [SUM_W-1:0]  sweep_sum;
    fusion_result_t           expected_results [$];
    int                       errors;

    function new();
      for (int s = 0; s < N_SENS; s++) begin
        cfg[s].alpha  = ALPHA_RESET;
        cfg[s].offset = '0;
        cfg[s].weight = (s == 0) ? WEIGHT0_RESET : WEIGHTN_RESET;
        smoothed[s]   = '0;
      end
      sweep_sum = '0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Alpha and weight above 1000 act as 1000.
    function longint per_mille(logic [PM_W-1:0] v);
      return (v > PER_MILLE) ? longint'(PER_MILLE) : longint'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      int s;
      int ofs;
      s   = int'(index) / REGS_PER_SENSOR;
      ofs = int'(index) % REGS_PER_SENSOR;
      if (s >= N_SENS) return;
      case (ofs)
        REG_ALPHA_OFS:  cfg[s].alpha  = data[PM_W-1:0];
        REG_OFFSET_OFS: cfg[s].offset = data[OFFSET_W-1:0];
        REG_WEIGHT_OFS: cfg[s].weight = data[PM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [IDX_W-1:0] idx, logic signed [SAMPLE_W-1:0] value,
                               logic last);
      fusion_result_t r;
      longint x, a, w, prev, f, s;
      f = 0;
      if (int'(idx) < N_SENS) begin
        x    = longint'(value) - longint'($signed(cfg[idx].offset));
        a    = per_mille(cfg[idx].alpha);
        w    = per_mille(cfg[idx].weight);
        prev = longint'(smoothed[idx]);
        // A stored zero means the sensor has not been seeded yet.
        if (prev == 0) f = x;
        else f = (a * x + (longint'(PER_MILLE) - a) * prev) / longint'(PER_MILLE);
        smoothed[idx] = FILT_W'(f);
        s = longint'(sweep_sum) + (w * f) / longint'(PER_MILLE);
        if (s > longint'(SUM_MAX)) s = longint'(SUM_MAX);
        if (s < longint'(SUM_MIN)) s = longint'(SUM_MIN);
        sweep_sum = SUM_W'(s);
      end
      r.filt = FILT_W'(f);
      r.sum  = sweep_sum;
      r.done = last;
      expected_results.push_back(r);
      if (last) sweep_sum = '0;
    endfunction

    function void check_result(logic signed [FILT_W-1:0] filt, logic signed [SUM_W-1:0] sum,
                               logic done);
      fusion_result_t r;
      if (expected_results.size() == 0) begin
        $error("result with no request waiting: filtered_value %0d running_sum %0d",
               filt, sum);
        errors++;
        return;
      end
      r = expected_results.pop_front();
      if (filt !== r.filt) begin
        $error("filtered_value: expected %0d, actual %0d", r.filt, filt);
        errors++;
      end
      if (sum !== r.sum) begin
        $error("running_sum: expected %0d, actual %0d", r.sum, sum);
        errors++;
      end
      if (done !== r.done) begin
        $error("sweep_done: expected %0b, actual %0b", r.done, done);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [IDX_W-1:0]             sensor_index = '0;
  logic signed [SAMPLE_W-1:0]   sample = '0;
  logic                         last_sensor = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [FILT_W-1:0]     filtered_value;
  logic signed [SUM_W-1:0]      running_sum;
  logic                         sweep_done;

  temp_fusion_scoreboard sb;
  sensor_cfg_t           next_cfg [N_SENS];
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    hold_trigger = 0;
  int                    quiet_cycles = 0;

  weighted_ema_virtual_temp_sensor_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sensor_index   (sensor_index),
    .sample         (sample),
    .last_sensor    (last_sensor),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value),
    .running_sum    (running_sum),
    .sweep_done     (sweep_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_request(sensor_index, sample, last_sensor);
      if (out_valid && !out_stall) sb.check_result(filtered_value, running_sum, sweep_done);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    int seen;
    int left;
    seen = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_trigger != seen) begin
        seen = hold_trigger;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic logic [IDX_W-1:0] rand_sensor();
    return IDX_W'($urandom_range(N_SENS - 1));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(logic [IDX_W-1:0] idx);
    longint v;
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: begin
        // Close to the offset, so the corrected value is often exactly zero.
        v = longint'($signed(next_cfg[idx].offset)) + longint'($urandom_range(6)) - 3;
        return SAMPLE_W'(v);
      end
      3: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [PM_W-1:0] pick_per_mille();
    case ($urandom_range(5))
      0: return '0;
      1: return PER_MILLE;
      2: return PM_W'($urandom_range(1001, 1023));
      default: return PM_W'($urandom_range(1000));
    endcase
  endfunction

  function automatic logic signed [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(5))
      0: return OFFSET_MIN;
      1: return OFFSET_MAX;
      2: return '0;
      default: return OFFSET_W'($urandom);
    endcase
  endfunction

  function automatic void set_cfg(int s, logic [PM_W-1:0] alpha,
                                  logic signed [OFFSET_W-1:0] offset, logic [PM_W-1:0] weight);
    next_cfg[s].alpha  = alpha;
    next_cfg[s].offset = offset;
    next_cfg[s].weight = weight;
  endfunction

  task automatic drive_reg(int index, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= CFG_IDX_W'(index);
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Unused upper data bits of the per-mille registers carry random junk.
  task automatic apply_config();
    for (int s = 0; s < N_SENS; s++) begin
      drive_reg(s * REGS_PER_SENSOR + REG_ALPHA_OFS,
                {(CFG_DATA_W - PM_W)'($urandom), next_cfg[s].alpha});
      drive_reg(s * REGS_PER_SENSOR + REG_OFFSET_OFS, CFG_DATA_W'(next_cfg[s].offset));
      drive_reg(s * REGS_PER_SENSOR + REG_WEIGHT_OFS,
                {(CFG_DATA_W - PM_W)'($urandom), next_cfg[s].weight});
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_reading(logic [IDX_W-1:0] idx, logic signed [SAMPLE_W-1:0] value,
                              logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sensor_index <= idx;
    sample       <= value;
    last_sensor  <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // The extra edge lets the last accepted request reach the scoreboard first.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(int count);
    int               sent;
    int               kind;
    int               run;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] idx;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        first = rand_sensor();
        send_reading(first, pick_sample(first), 1'b0);
        idx = first ^ 1'b1;
        send_reading(idx, pick_sample(idx), 1'b1);
        sent += 2;
      end else if (kind == 6) begin
        idx = rand_sensor();
        send_reading(idx, pick_sample(idx), 1'b1);
        sent++;
      end else if (kind == 7) begin
        // Sweep with the end marker held back, pushing the sum toward its limits.
        run = $urandom_range(3, 10);
        repeat (run) begin
          idx = rand_sensor();
          send_reading(idx, pick_sample(idx), 1'b0);
        end
        idx = rand_sensor();
        send_reading(idx, pick_sample(idx), 1'b1);
        sent += run + 1;
      end else begin
        idx = rand_sensor();
        send_reading(idx, pick_sample(idx), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic directed_requests();
    // Reset settings: zero samples leave the sensors unseeded.
    send_reading(1'b0, '0, 1'b0);
    send_reading(1'b1, '0, 1'b1);
    send_reading(1'b0, SAMPLE_MAX, 1'b0);
    send_reading(1'b0, SAMPLE_MAX, 1'b0);
    send_reading(1'b1, SAMPLE_MIN, 1'b1);

    // Offset extremes and per-mille values above range; the sum saturates
    // high and then low before the end marker comes.
    set_cfg(0, 10'd500, OFFSET_MIN, PER_MILLE);
    set_cfg(1, PM_TOP, OFFSET_MAX, PM_TOP);
    drain_pipeline();
    apply_config();
    repeat (3) send_reading(1'b0, SAMPLE_MAX, 1'b0);
    repeat (6) send_reading(1'b1, SAMPLE_MIN, 1'b0);
    send_reading(1'b1, SAMPLE_MIN, 1'b1);

    // A seeded sensor corrected to zero with full alpha drops back to
    // unseeded; zero alpha holds the old value.
    set_cfg(0, PER_MILLE, 17'sd12345, '0);
    set_cfg(1, '0, -17'sd1, PER_MILLE);
    drain_pipeline();
    apply_config();
    send_reading(1'b0, 18'sd12345, 1'b0);
    send_reading(1'b0, -18'sd5, 1'b0);
    send_reading(1'b1, 18'sd7, 1'b1);
    send_reading(1'b1, -18'sd1, 1'b1);
    send_reading(1'b0, SAMPLE_MIN, 1'b1);
    send_reading(1'b1, SAMPLE_MAX, 1'b0);
    send_reading(1'b0, SAMPLE_MAX, 1'b1);
  endtask

  initial begin
    int send_pcts [4];
    int recv_pcts [4];
    send_pcts = '{0, 64, 0, 19};
    recv_pcts = '{0, 0, 64, 19};
    sb = new();
    for (int s = 0; s < N_SENS; s++) begin
      set_cfg(s, ALPHA_RESET, '0, (s == 0) ? WEIGHT0_RESET : WEIGHTN_RESET);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_requests();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (int blk = 0; blk < 3; blk++) begin
        drain_pipeline();
        for (int s = 0; s < N_SENS; s++) begin
          if (ph == 0 && blk == 0) set_cfg(s, PM_TOP, OFFSET_MAX, PM_TOP);
          else if (ph == 1 && blk == 0) set_cfg(s, '0, OFFSET_MIN, '0);
          else if (ph == 3 && blk == 0) set_cfg(s, PER_MILLE, '0, PER_MILLE);
          else set_cfg(s, pick_per_mille(), pick_offset(), pick_per_mille());
        end
        apply_config();
        if (ph == 0 && blk == 1) begin
          // Output held off while requests keep coming, so the input backs up.
          hold_trigger++;
          random_traffic(40);
        end
        if (ph == 3 && blk == 1) begin
          random_traffic(BLOCK_ITEMS / 2);
          drain_pipeline();
          random_traffic(BLOCK_ITEMS / 2);
        end else begin
          random_traffic(BLOCK_ITEMS);
        end
      end
    end

    drain_pipeline();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/wema_pkg.sv
src/wema_cfg.sv
src/wema_filter.sv
src/wema_accum.sv
src/weighted_ema_virtual_temp_sensor_top.sv
tb/sv/weighted_ema_virtual_temp_sensor_top_tb.sv
